/* src/hmla_pkg.sv */
`default_nettype none
package hmla_pkg;

  // input item kinds
  typedef enum logic [1:0] {
    KIND_WEIGHT = 2'd0,
    KIND_HIST   = 2'd1,
    KIND_USER   = 2'd2,
    KIND_GRAD   = 2'd3
  } kind_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_DIMS  = 2'd0,
    REG_GAMMA = 2'd1,
    REG_LR    = 2'd2,
    REG_BATCH = 2'd3
  } reg_idx_t;

  // shared multiply-accumulate unit
  localparam int MAC_AW  = 21;
  localparam int MAC_BW  = 18;
  localparam int MAC_PW  = MAC_AW + MAC_BW;
  localparam int MAC_ACW = 64;

  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_12 = 2'd1,
    SH_20 = 2'd2
  } mac_shift_t;

  typedef struct packed {
    logic       en;
    logic       clr;
    logic       load;
    mac_shift_t sh;
  } mac_ctrl_t;

  // shared divider
  localparam int DIV_NW = 33;
  localparam int DIV_DW = 13;
  localparam int DIV_CW = 6;

endpackage
`default_nettype wire

/* src/hmla_mac.sv */
`default_nettype none
module hmla_mac (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire hmla_pkg::mac_ctrl_t                 ctrl,
  input  wire logic signed [hmla_pkg::MAC_AW-1:0]  op_a,
  input  wire logic signed [hmla_pkg::MAC_BW-1:0]  op_b,
  input  wire logic signed [hmla_pkg::MAC_ACW-1:0] addend,
  output logic signed [hmla_pkg::MAC_ACW-1:0]      acc
);
  import hmla_pkg::*;

  logic signed [MAC_PW-1:0]  prod;
  logic signed [MAC_ACW-1:0] add_q;
  mac_ctrl_t                 ctrl_q;
  logic signed [MAC_ACW-1:0] prod_ext;
  logic signed [MAC_ACW-1:0] prod_sh;

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl;
    end
    prod  <= op_a * op_b;
    add_q <= addend;
  end

  // alignment of the product
  assign prod_ext = MAC_ACW'(prod);
  always_comb begin
    case (ctrl_q.sh)
      SH_12:   prod_sh = prod_ext <<< 12;
      SH_20:   prod_sh = prod_ext <<< 20;
      default: prod_sh = prod_ext;
    endcase
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    if (ctrl_q.clr) begin
      acc <= '0;
    end else if (ctrl_q.en) begin
      acc <= (ctrl_q.load ? add_q : acc) + prod_sh;
    end
  end

endmodule
`default_nettype wire

/* src/hmla_div.sv */
`default_nettype none
module hmla_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [hmla_pkg::DIV_NW-1:0]   num,
  input  wire logic [hmla_pkg::DIV_DW-1:0]   den,
  output logic                               done,
  output logic [hmla_pkg::DIV_NW-1:0]        quot,
  output logic [hmla_pkg::DIV_DW-1:0]        rem
);
  import hmla_pkg::*;

  logic              run;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_DW:0]   trial;
  logic              fits;

  // one quotient bit per cycle, restoring
  assign trial = {rem, quot[DIV_NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= DIV_CW'(DIV_NW);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot  <= num;
      rem   <= '0;
      den_r <= den;
    end else if (run) begin
      rem  <= fits ? DIV_DW'(trial - {1'b0, den_r}) : DIV_DW'(trial);
      quot <= {quot[DIV_NW-2:0], fits};
    end
  end

endmodule
`default_nettype wire

/* src/history_mean_linear_aggregator_core.sv */
`default_nettype none
// History-mean linear aggregator.
// Items enter on start/kind/row_index/dim_index/value/history_count/last and
// are taken when start is high and busy is low. User and gradient elements
// give one result on result_value/result_dim/result_last/saturated, shown for
// a single cycle with result_valid; the receiver cannot stall, so results are
// never held. Weight writes and history elements give no result.
// Work per item (one shared multiply-accumulate unit, one serial divider):
//   weight write stores one weight; history element updates one sum; a last
//   history element adds a mean pass over EMB_DIM_MAX dimensions (one divide each);
//   user element walks over n weights (n = dimensions in use);
//   gradient element walks over n accumulator entries, plus a batch check on a last
//   element, plus a weight update pass when the update runs
//   (every entry of the square matrix, one divide each).
// After reset the block clears the gradient accumulator, the history sums
// and the means in one pass over every matrix entry, with busy high;
// configuration writes are taken at any time.
// Registers sit on the APB port at byte addresses 0, 4, 8 and 12.
module history_mean_linear_aggregator_core #(
  parameter int EMB_DIM_MAX = 64,
  parameter int HISTORY_MAX = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         kind,
  input  wire logic [5:0]         row_index,
  input  wire logic [5:0]         dim_index,
  input  wire logic signed [15:0] value,
  input  wire logic [8:0]         history_count,
  input  wire logic               last,
  output logic                    result_valid,
  output logic signed [15:0]      result_value,
  output logic [5:0]              result_dim,
  output logic                    result_last,
  output logic                    saturated,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import hmla_pkg::*;

  localparam int AW     = $clog2(EMB_DIM_MAX);
  localparam int MW     = 2 * AW;
  localparam int MDEPTH = 1 << MW;

  typedef enum logic [24:0] {
    ST_CLEAR  = 25'h0000001,
    ST_IDLE   = 25'h0000002,
    ST_HADD   = 25'h0000004,
    ST_MRD    = 25'h0000008,
    ST_MGO    = 25'h0000010,
    ST_MWAIT  = 25'h0000020,
    ST_WALK   = 25'h0000040,
    ST_DRAIN  = 25'h0000080,
    ST_FLATCH = 25'h0000100,
    ST_FMUL0  = 25'h0000200,
    ST_FMUL1  = 25'h0000400,
    ST_FMUL2  = 25'h0000800,
    ST_FRES   = 25'h0001000,
    ST_GMUL0  = 25'h0002000,
    ST_GRES   = 25'h0004000,
    ST_GMUL1  = 25'h0008000,
    ST_GH     = 25'h0010000,
    ST_RESULT = 25'h0020000,
    ST_CHK    = 25'h0040000,
    ST_CWAIT  = 25'h0080000,
    ST_URD    = 25'h0100000,
    ST_UM0    = 25'h0200000,
    ST_UM1    = 25'h0400000,
    ST_UGO    = 25'h0800000,
    ST_UWAIT  = 25'h1000000
  } state_t;

  // configuration registers
  logic [6:0]  dims_in_use;
  logic [15:0] blend_gamma;
  logic [15:0] learn_rate;
  logic [10:0] batch_size;

  // sequencer and item registers
  state_t              state;
  state_t              ret_st;
  logic                drain_cnt;
  logic [MW-1:0]       idx;
  kind_t               cur_kind;
  logic [5:0]          cur_dim;
  logic signed [15:0]  cur_val;
  logic [8:0]          cur_count;
  logic                cur_last;
  logic                cur_in;
  logic [15:0]         res_reg;
  logic                sat_reg;
  logic [37:0]         f_reg;
  logic signed [16:0]  h_reg;
  logic [39:0]         a_reg;
  logic signed [15:0]  w_reg;
  logic                neg_reg;
  logic [31:0]         forward_count;
  logic                rd_v;
  logic                v2;
  logic                v3;
  logic [MW-1:0]       addr1;
  logic [MW-1:0]       addr2;
  logic [MW-1:0]       addr3;

  // memories
  logic signed [15:0] wmem [MDEPTH];
  logic signed [39:0] amem [MDEPTH];
  logic signed [31:0] smem [EMB_DIM_MAX];
  logic signed [15:0] mmem [EMB_DIM_MAX];
  logic signed [15:0] wdata;
  logic signed [39:0] adata;
  logic signed [31:0] sdata;
  logic signed [15:0] mdata;

  logic [MW-1:0] w_raddr;
  logic [AW-1:0] s_raddr;
  logic          w_we;
  logic [MW-1:0] w_waddr;
  logic [15:0]   w_wdata;
  logic          a_we;
  logic [MW-1:0] a_waddr;
  logic [39:0]   a_wdata;
  logic          s_we;
  logic [AW-1:0] s_waddr;
  logic [31:0]   s_wdata;
  logic          m_we;
  logic [AW-1:0] m_waddr;
  logic [15:0]   m_wdata;

  // shared units
  mac_ctrl_t                  mac_ctrl;
  logic signed [MAC_AW-1:0]   mac_a;
  logic signed [MAC_BW-1:0]   mac_b;
  logic signed [MAC_ACW-1:0]  mac_add;
  logic signed [MAC_ACW-1:0]  acc;
  logic                       div_start;
  logic [DIV_NW-1:0]          div_num;
  logic [DIV_DW-1:0]          div_den;
  logic                       div_done;
  logic [DIV_NW-1:0]          div_quot;
  logic [DIV_DW-1:0]          div_rem;

  // derived values
  logic [8:0]          n_use;
  logic [10:0]         b_eff;
  logic [12:0]         c_eff;
  logic [16:0]         ogam;
  logic                acc_item;
  logic                dim_ok;
  logic                row_ok;
  logic                walk_end;
  logic signed [32:0]  s_ext;
  logic [32:0]         s_abs;
  logic [63:0]         acc_abs;
  logic signed [63:0]  blend_rnd;
  logic signed [63:0]  grad_rnd;
  logic signed [63:0]  q_s;
  logic signed [63:0]  w_new;
  logic signed [63:0]  hsum;
  logic [31:0]         hsum_sat;
  logic [39:0]         acc_sat;
  logic [16:0]         blend_sat;
  logic [16:0]         grad_sat;
  logic [16:0]         mean_sat;
  logic [16:0]         w_sat;

  function automatic logic [16:0] sat16(input logic signed [63:0] x);
    if (x > 64'sd32767) begin
      return {1'b1, 16'h7fff};
    end else if (x < -64'sd32768) begin
      return {1'b1, 16'h8000};
    end
    return {1'b0, x[15:0]};
  endfunction

  hmla_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .op_a   (mac_a),
    .op_b   (mac_b),
    .addend (mac_add),
    .acc    (acc)
  );

  hmla_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  // configuration port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      dims_in_use <= 7'd64;
      blend_gamma <= 16'd26214;
      learn_rate  <= 16'd655;
      batch_size  <= 11'd32;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_DIMS:  dims_in_use <= pwdata[6:0];
        REG_GAMMA: blend_gamma <= pwdata[15:0];
        REG_LR:    learn_rate  <= pwdata[15:0];
        REG_BATCH: batch_size  <= pwdata[10:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DIMS:  prdata = 32'(dims_in_use);
      REG_GAMMA: prdata = 32'(blend_gamma);
      REG_LR:    prdata = 32'(learn_rate);
      REG_BATCH: prdata = 32'(batch_size);
      default:   prdata = '0;
    endcase
  end

  // effective settings
  always_comb begin
    if (dims_in_use == 7'd0) begin
      n_use = 9'd1;
    end else if ({2'b0, dims_in_use} > 9'(EMB_DIM_MAX)) begin
      n_use = 9'(EMB_DIM_MAX);
    end else begin
      n_use = {2'b0, dims_in_use};
    end
    if (cur_count == 9'd0) begin
      c_eff = 13'd1;
    end else if ({4'b0, cur_count} > 13'(HISTORY_MAX)) begin
      c_eff = 13'(HISTORY_MAX);
    end else begin
      c_eff = {4'b0, cur_count};
    end
  end

  assign b_eff    = (batch_size == 11'd0) ? 11'd1 : batch_size;
  assign ogam     = 17'h10000 - {1'b0, blend_gamma};
  assign acc_item = start && !busy;
  assign dim_ok   = {3'b0, dim_index} < n_use;
  assign row_ok   = {3'b0, row_index} < n_use;
  assign walk_end = (9'(idx[AW-1:0]) + 9'd1) == n_use;

  // rounding and saturation
  assign s_ext     = 33'(sdata);
  assign s_abs     = sdata[31] ? 33'(-s_ext) : 33'(s_ext);
  assign acc_abs   = acc[63] ? 64'(-acc) : 64'(acc);
  assign blend_rnd = (acc + 64'sd134217728) >>> 28;
  assign grad_rnd  = (acc + 64'sd32768) >>> 16;
  assign q_s       = neg_reg ? -$signed(64'(div_quot)) : $signed(64'(div_quot));
  assign w_new     = 64'(w_reg) - q_s;
  assign hsum      = 64'(sdata) + 64'(cur_val);
  assign blend_sat = sat16(blend_rnd);
  assign grad_sat  = sat16(grad_rnd);
  assign mean_sat  = sat16(q_s);
  assign w_sat     = sat16(w_new);

  always_comb begin
    if (hsum > 64'sd2147483647) begin
      hsum_sat = 32'h7fff_ffff;
    end else if (hsum < -64'sd2147483648) begin
      hsum_sat = 32'h8000_0000;
    end else begin
      hsum_sat = hsum[31:0];
    end
    if (acc > 64'sd549755813887) begin
      acc_sat = 40'h7f_ffff_ffff;
    end else if (acc < -64'sd549755813888) begin
      acc_sat = 40'h80_0000_0000;
    end else begin
      acc_sat = acc[39:0];
    end
  end

  // read addresses
  assign w_raddr = (state == ST_WALK) ? {idx[AW-1:0], AW'(cur_dim)} : idx;
  assign s_raddr = (state == ST_IDLE) ? AW'(dim_index) : idx[AW-1:0];

  // write ports
  always_comb begin
    w_we    = 1'b0;
    w_waddr = idx;
    w_wdata = w_sat[15:0];
    a_we    = 1'b0;
    a_waddr = idx;
    a_wdata = '0;
    s_we    = 1'b0;
    s_waddr = idx[AW-1:0];
    s_wdata = '0;
    m_we    = 1'b0;
    m_waddr = idx[AW-1:0];
    m_wdata = mean_sat[15:0];
    if (state == ST_CLEAR) begin
      a_we = 1'b1;
      s_we = 1'b1;
      m_we = 1'b1;
      m_wdata = '0;
    end
    if (state == ST_IDLE && acc_item && kind == KIND_WEIGHT && row_ok && dim_ok) begin
      w_we    = 1'b1;
      w_waddr = {AW'(row_index), AW'(dim_index)};
      w_wdata = value;
    end
    if (state == ST_HADD && cur_in) begin
      s_we    = 1'b1;
      s_waddr = AW'(cur_dim);
      s_wdata = hsum_sat;
    end
    if (state == ST_MWAIT && div_done) begin
      s_we = 1'b1;
      m_we = 1'b1;
    end
    if (v3) begin
      a_we    = 1'b1;
      a_waddr = addr3;
      a_wdata = acc_sat;
    end
    if (state == ST_UWAIT && div_done) begin
      w_we = 1'b1;
      a_we = 1'b1;
    end
  end

  // memory arrays
  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_waddr] <= w_wdata;
    end
    wdata <= wmem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      amem[a_waddr] <= a_wdata;
    end
    adata <= amem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      smem[s_waddr] <= s_wdata;
    end
    sdata <= smem[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (m_we) begin
      mmem[m_waddr] <= m_wdata;
    end
    mdata <= mmem[idx[AW-1:0]];
  end

  // multiply-accumulate operand selection
  always_comb begin
    mac_ctrl = '{en: 1'b0, clr: 1'b0, load: 1'b0, sh: SH_0};
    mac_a    = '0;
    mac_b    = '0;
    mac_add  = 64'(adata);
    if (rd_v) begin
      mac_ctrl.en   = 1'b1;
      mac_ctrl.load = (cur_kind == KIND_GRAD);
      mac_a         = MAC_AW'(mdata);
      mac_b         = (cur_kind == KIND_GRAD) ? MAC_BW'(h_reg) : MAC_BW'(wdata);
    end else begin
      unique case (state)
        ST_IDLE, ST_FLATCH, ST_GRES, ST_URD: begin
          mac_ctrl.clr = 1'b1;
        end
        ST_FMUL0: begin
          mac_ctrl.en = 1'b1;
          mac_ctrl.sh = SH_12;
          mac_a       = MAC_AW'(cur_val);
          mac_b       = MAC_BW'({1'b0, blend_gamma});
        end
        ST_FMUL1: begin
          mac_ctrl.en = 1'b1;
          mac_a       = MAC_AW'({1'b0, f_reg[19:0]});
          mac_b       = MAC_BW'(ogam);
        end
        ST_FMUL2: begin
          mac_ctrl.en = 1'b1;
          mac_ctrl.sh = SH_20;
          mac_a       = MAC_AW'($signed(f_reg[37:20]));
          mac_b       = MAC_BW'(ogam);
        end
        ST_GMUL0: begin
          mac_ctrl.en = 1'b1;
          mac_a       = MAC_AW'(cur_val);
          mac_b       = MAC_BW'({1'b0, blend_gamma});
        end
        ST_GMUL1: begin
          mac_ctrl.en = 1'b1;
          mac_a       = MAC_AW'(cur_val);
          mac_b       = MAC_BW'(ogam);
        end
        ST_UM0: begin
          mac_ctrl.en = 1'b1;
          mac_a       = MAC_AW'({1'b0, adata[19:0]});
          mac_b       = MAC_BW'({1'b0, learn_rate});
        end
        ST_UM1: begin
          mac_ctrl.en = 1'b1;
          mac_ctrl.sh = SH_20;
          mac_a       = MAC_AW'($signed(a_reg[39:20]));
          mac_b       = MAC_BW'({1'b0, learn_rate});
        end
        default: ;
      endcase
    end
  end

  // divider operand selection
  always_comb begin
    div_start = 1'b0;
    div_num   = 33'(acc_abs + (64'(b_eff) << 27)) >> 0;
    div_den   = 13'(b_eff);
    if (state == ST_MGO) begin
      div_start = 1'b1;
      div_num   = s_abs + 33'(c_eff >> 1);
      div_den   = c_eff;
    end else if (state == ST_CHK) begin
      div_start = 1'b1;
      div_num   = {1'b0, forward_count};
    end else if (state == ST_UGO) begin
      div_start = 1'b1;
      div_num   = 33'((acc_abs + (64'(b_eff) << 27)) >> 28);
    end
  end

  // write-back pipeline of the accumulator walk
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
    end else begin
      rd_v <= (state == ST_WALK);
      v2   <= rd_v && (cur_kind == KIND_GRAD);
      v3   <= v2;
    end
    addr1 <= w_raddr;
    addr2 <= addr1;
    addr3 <= addr2;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      ret_st        <= ST_IDLE;
      drain_cnt     <= 1'b0;
      idx           <= '0;
      forward_count <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          idx <= idx + 1'b1;
          if (idx == {MW{1'b1}}) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          idx <= '0;
          if (acc_item) begin
            unique case (kind_t'(kind))
              KIND_WEIGHT: state <= ST_IDLE;
              KIND_HIST:   state <= ST_HADD;
              KIND_USER:   state <= dim_ok ? ST_WALK : ST_RESULT;
              KIND_GRAD:   state <= dim_ok ? ST_GMUL0 : ST_RESULT;
              default:     state <= ST_IDLE;
            endcase
          end
        end
        ST_HADD: begin
          state <= cur_last ? ST_MRD : ST_IDLE;
        end
        ST_MRD: begin
          state <= ST_MGO;
        end
        ST_MGO: begin
          state <= ST_MWAIT;
        end
        ST_MWAIT: begin
          if (div_done) begin
            if (idx[AW-1:0] == AW'(EMB_DIM_MAX - 1)) begin
              state <= ST_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_MRD;
            end
          end
        end
        ST_WALK: begin
          if (walk_end) begin
            drain_cnt <= 1'b1;
            ret_st    <= (cur_kind == KIND_USER) ? ST_FLATCH : ST_RESULT;
            state     <= ST_DRAIN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (drain_cnt) begin
            drain_cnt <= 1'b0;
          end else begin
            state <= ret_st;
          end
        end
        ST_FLATCH: state <= ST_FMUL0;
        ST_FMUL0:  state <= ST_FMUL1;
        ST_FMUL1:  state <= ST_FMUL2;
        ST_FMUL2: begin
          ret_st <= ST_FRES;
          state  <= ST_DRAIN;
        end
        ST_FRES: state <= ST_RESULT;
        ST_GMUL0: begin
          ret_st <= ST_GRES;
          state  <= ST_DRAIN;
        end
        ST_GRES: state <= ST_GMUL1;
        ST_GMUL1: begin
          ret_st <= ST_GH;
          state  <= ST_DRAIN;
        end
        ST_GH: begin
          idx   <= '0;
          state <= ST_WALK;
        end
        ST_RESULT: begin
          if (cur_kind == KIND_USER && cur_last) begin
            forward_count <= forward_count + 1'b1;
          end
          state <= (cur_kind == KIND_GRAD && cur_last) ? ST_CHK : ST_IDLE;
        end
        ST_CHK: state <= ST_CWAIT;
        ST_CWAIT: begin
          if (div_done) begin
            idx   <= '0;
            state <= (forward_count != 32'd0 && div_rem == '0) ? ST_URD : ST_IDLE;
          end
        end
        ST_URD: state <= ST_UM0;
        ST_UM0: state <= ST_UM1;
        ST_UM1: begin
          ret_st <= ST_UGO;
          state  <= ST_DRAIN;
        end
        ST_UGO: state <= ST_UWAIT;
        ST_UWAIT: begin
          if (div_done) begin
            idx <= idx + 1'b1;
            state <= (idx == {MW{1'b1}}) ? ST_IDLE : ST_URD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // item and datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && acc_item) begin
      cur_kind  <= kind_t'(kind);
      cur_dim   <= dim_index;
      cur_val   <= value;
      cur_count <= history_count;
      cur_last  <= last;
      cur_in    <= dim_ok;
      res_reg   <= '0;
      sat_reg   <= 1'b0;
    end
    if (state == ST_FLATCH) begin
      f_reg <= acc[37:0];
    end
    if (state == ST_FRES) begin
      res_reg <= blend_sat[15:0];
      sat_reg <= blend_sat[16];
    end
    if (state == ST_GRES) begin
      res_reg <= grad_sat[15:0];
      sat_reg <= grad_sat[16];
    end
    if (state == ST_GH) begin
      h_reg <= 17'(grad_rnd);
    end
    if (state == ST_UM0) begin
      a_reg <= adata;
      w_reg <= wdata;
    end
    if (state == ST_MGO) begin
      neg_reg <= sdata[31];
    end
    if (state == ST_UGO) begin
      neg_reg <= acc[63];
    end
  end

  // status and result ports
  assign busy         = (state != ST_IDLE);
  assign result_valid = (state == ST_RESULT);
  assign result_value = res_reg;
  assign result_dim   = cur_dim;
  assign result_last  = cur_last;
  assign saturated    = sat_reg;

endmodule
`default_nettype wire

/* tb/testbench.sv */
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hmla_pkg::*;

  localparam int DMAX = 64;
  localparam int CYCLE_LIMIT = 20000000;
  localparam int SETTLE_CYCLES = 3000;

  typedef struct {
    kind_t             kind;
    logic [5:0]        row;
    logic [5:0]        dim;
    logic signed [15:0] val;
    logic [8:0]        cnt;
    logic              lst;
  } element_t;

  typedef struct {
    logic signed [15:0] val;
    logic [5:0]        dim;
    logic              lst;
    logic              sat;
  } blend_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] kind = '0;
  logic [5:0] row_index = '0;
  logic [5:0] dim_index = '0;
  logic signed [15:0] value = '0;
  logic [8:0] history_count = '0;
  logic last = 1'b0;
  logic result_valid;
  logic signed [15:0] result_value;
  logic [5:0] result_dim;
  logic result_last;
  logic saturated;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  history_mean_linear_aggregator_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .kind(kind), .row_index(row_index), .dim_index(dim_index), .value(value),
    .history_count(history_count), .last(last),
    .result_valid(result_valid), .result_value(result_value),
    .result_dim(result_dim), .result_last(result_last), .saturated(saturated),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // mirror of the block state
  logic signed [15:0] weights [DMAX*DMAX];
  longint hist_sums [DMAX];
  logic signed [15:0] means [DMAX];
  longint grad_acc [DMAX*DMAX];
  int unsigned forwards;
  logic [6:0] dims_reg;
  logic [15:0] gamma_reg;
  logic [15:0] lr_reg;
  logic [10:0] batch_reg;

  element_t pending_elems[$];
  blend_out_t expected_outs[$];
  element_t cur;
  int idle_pct = 12;
  int errors = 0;
  int cycles = 0;

  // stimulus planning: forward count and allowed weight updates
  int unsigned plan_fwd = 0;
  int update_budget = 2;

  function automatic longint round_half_up(longint x, int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint div_away(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint clamp(longint x, longint lo, longint hi);
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  function automatic int dims_eff();
    if (dims_reg < 1) return 1;
    if (dims_reg > DMAX) return DMAX;
    return dims_reg;
  endfunction

  function automatic int batch_eff();
    return (batch_reg == 0) ? 1 : batch_reg;
  endfunction

  // apply W -= lr*accum/batch and clear the accumulator
  function automatic void apply_weight_step();
    longint den;
    longint step;
    den = longint'(batch_eff()) <<< 28;
    for (int k = 0; k < DMAX*DMAX; k++) begin
      step = div_away(grad_acc[k] * longint'(lr_reg), den);
      weights[k] = 16'(clamp(longint'(weights[k]) - step, -32768, 32767));
      grad_acc[k] = 0;
    end
  endfunction

  // update mirrored state for one element and queue its output if any
  function automatic void absorb_element(element_t e);
    int n;
    longint gam, ogam, f, acc, h, res, c;
    blend_out_t o;
    n = dims_eff();
    gam = gamma_reg;
    ogam = 65536 - gam;
    res = 0;
    case (e.kind)
      KIND_WEIGHT: begin
        if (e.row < n && e.dim < n) weights[e.row*DMAX + e.dim] = e.val;
      end
      KIND_HIST: begin
        if (e.dim < n)
          hist_sums[e.dim] = clamp(hist_sums[e.dim] + e.val, -64'sd2147483648, 64'sd2147483647);
        if (e.lst) begin
          c = (e.cnt == 0) ? 1 : e.cnt;
          if (c > 256) c = 256;
          for (int i = 0; i < DMAX; i++) begin
            means[i] = 16'(clamp(div_away(hist_sums[i], c), -32768, 32767));
            hist_sums[i] = 0;
          end
        end
      end
      KIND_USER: begin
        if (e.dim < n) begin
          f = 0;
          for (int i = 0; i < n; i++)
            f += longint'(means[i]) * longint'(weights[i*DMAX + e.dim]);
          acc = longint'(e.val) * gam * 4096 + f * ogam;
          res = round_half_up(acc, 28);
        end
        if (e.lst) forwards++;
      end
      default: begin
        if (e.dim < n) begin
          h = round_half_up(longint'(e.val) * ogam, 16);
          for (int i = 0; i < n; i++)
            grad_acc[i*DMAX + e.dim] = clamp(grad_acc[i*DMAX + e.dim] + longint'(means[i]) * h,
                                             -64'sd549755813888, 64'sd549755813887);
          res = round_half_up(longint'(e.val) * gam, 16);
        end
        if (e.lst && forwards > 0 && forwards % batch_eff() == 0) apply_weight_step();
      end
    endcase
    if (e.kind == KIND_USER || e.kind == KIND_GRAD) begin
      o.sat = (res > 32767 || res < -32768);
      o.val = 16'(clamp(res, -32768, 32767));
      o.dim = e.dim;
      o.lst = e.lst;
      expected_outs.push_back(o);
    end
  endfunction

  // driver: present pending elements, hold until taken
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) absorb_element(cur);
      if (pending_elems.size() > 0 && $urandom_range(99) >= idle_pct) begin
        cur = pending_elems.pop_front();
        start <= 1'b1;
        kind <= cur.kind;
        row_index <= cur.row;
        dim_index <= cur.dim;
        value <= cur.val;
        history_count <= cur.cnt;
        last <= cur.lst;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: compare each output transaction with the oldest expectation
  always @(posedge clk) begin
    blend_out_t o;
    if (!rst && result_valid) begin
      if (expected_outs.size() == 0) begin
        $error("unexpected output transaction: value %0d dim %0d", result_value, result_dim);
        errors++;
      end else begin
        o = expected_outs.pop_front();
        if (result_value !== o.val) begin
          $error("result_value: expected %0d, actual %0d", o.val, result_value);
          errors++;
        end
        if (result_dim !== o.dim) begin
          $error("result_dim: expected %0d, actual %0d", o.dim, result_dim);
          errors++;
        end
        if (result_last !== o.lst) begin
          $error("result_last: expected %0d, actual %0d", o.lst, result_last);
          errors++;
        end
        if (saturated !== o.sat) begin
          $error("saturated: expected %0d, actual %0d", o.sat, saturated);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // queue an element; a gradient last that would start an unbudgeted update loses its flag
  function automatic void add(kind_t k, int r, int d, logic [15:0] v, int c, bit l);
    element_t e;
    if (k == KIND_USER && l) plan_fwd++;
    if (k == KIND_GRAD && l && plan_fwd > 0 && plan_fwd % batch_eff() == 0) begin
      if (update_budget > 0) update_budget--;
      else l = 1'b0;
    end
    e.kind = k;
    e.row = 6'(r);
    e.dim = 6'(d);
    e.val = v;
    e.cnt = 9'(c);
    e.lst = l;
    pending_elems.push_back(e);
  endfunction

  function automatic logic [15:0] rand_val();
    case ($urandom_range(9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2, 3, 4: return 16'($urandom_range(8191)) - 16'd4096;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic int pick_dim(int n);
    if ($urandom_range(9) == 0) return $urandom_range(63);
    return $urandom_range(n - 1);
  endfunction

  // random well-formed sequences with some noise
  function automatic void add_random(int target);
    int made, len, sel, n, cnt;
    kind_t k;
    made = 0;
    n = dims_eff();
    while (made < target) begin
      sel = $urandom_range(99);
      len = $urandom_range(1, 6);
      if (sel < 14) begin
        cnt = ($urandom_range(3) == 0) ? $urandom_range(511) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
          add(KIND_HIST, $urandom_range(63), pick_dim(n), rand_val(), cnt, i == len - 1);
        made += len;
      end else if (sel < 74) begin
        k = (sel < 44) ? KIND_USER : KIND_GRAD;
        for (int i = 0; i < len; i++)
          add(k, $urandom_range(63), pick_dim(n), rand_val(), $urandom_range(511),
              i == len - 1);
        made += len;
      end else if (sel < 84) begin
        add(KIND_WEIGHT, pick_dim(n), pick_dim(n), rand_val(), $urandom_range(511), 1'($urandom()));
        made++;
      end else begin
        add(kind_t'($urandom_range(3)), $urandom_range(63), $urandom_range(63), 16'($urandom()),
            $urandom_range(511), 1'($urandom()));
        made++;
      end
    end
  endfunction

  task automatic reg_write(reg_idx_t idx, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_DIMS: dims_reg = data[6:0];
      REG_GAMMA: gamma_reg = data[15:0];
      REG_LR: lr_reg = data[15:0];
      default: batch_reg = data[10:0];
    endcase
  endtask

  task automatic set_regs(int d, int g, int l, int b);
    reg_write(REG_DIMS, d);
    reg_write(REG_GAMMA, g);
    reg_write(REG_LR, l);
    reg_write(REG_BATCH, b);
  endtask

  // wait for every transaction and for the block to go quiet
  task automatic drain();
    while (pending_elems.size() != 0 || start || expected_outs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < DMAX*DMAX; i++) begin
      weights[i] = 0;
      grad_acc[i] = 0;
    end
    for (int i = 0; i < DMAX; i++) begin
      hist_sums[i] = 0;
      means[i] = 0;
    end
    forwards = 0;
    dims_reg = 64;
    gamma_reg = 26214;
    lr_reg = 655;
    batch_reg = 32;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // define the whole weight matrix before anything reads it
    for (int r = 0; r < DMAX; r++)
      for (int d = 0; d < DMAX; d++)
        add(KIND_WEIGHT, r, d, rand_val(), 0, 1'b0);

    // directed: extreme values, count of zero and above range, default registers
    add(KIND_WEIGHT, 0, 0, 16'h8000, 0, 1'b0);
    add(KIND_HIST, 0, 0, 16'h7fff, 0, 1'b0);
    add(KIND_HIST, 0, 1, 16'h8000, 0, 1'b0);
    add(KIND_HIST, 0, 63, 16'hffff, 0, 1'b0);
    add(KIND_HIST, 0, 5, 16'd20000, 1, 1'b1);
    add(KIND_USER, 63, 0, 16'h7fff, 0, 1'b0);
    add(KIND_USER, 0, 63, 16'h8000, 511, 1'b0);
    add(KIND_USER, 0, 7, 16'h0000, 0, 1'b1);
    add(KIND_GRAD, 0, 0, 16'h7fff, 0, 1'b0);
    add(KIND_GRAD, 0, 63, 16'h8000, 0, 1'b1);
    add(KIND_HIST, 0, 10, 16'd100, 511, 1'b1);
    add(KIND_HIST, 0, 3, 16'hfff9, 0, 1'b1);
    add(KIND_HIST, 0, 4, 16'h8000, 300, 1'b1);
    drain();

    // directed: full gamma and rate, weight update after one forward
    set_regs(64, 65535, 65535, 1);
    add(KIND_GRAD, 0, 1, 16'd1000, 0, 1'b1);
    add(KIND_USER, 0, 2, 16'h7fff, 0, 1'b1);
    drain();

    // directed: few dimensions in use, out-of-use indexes
    set_regs(3, 1, 1, 2047);
    add(KIND_WEIGHT, 50, 0, 16'h1234, 0, 1'b0);
    add(KIND_WEIGHT, 1, 2, 16'h7fff, 0, 1'b0);
    add(KIND_HIST, 0, 50, 16'h7fff, 2, 1'b1);
    add(KIND_USER, 0, 40, 16'h7fff, 0, 1'b1);
    add(KIND_GRAD, 0, 40, 16'h8000, 0, 1'b1);
    add(KIND_USER, 0, 2, 16'h4000, 0, 1'b0);
    add(KIND_GRAD, 0, 2, 16'hc000, 0, 1'b1);
    drain();

    // random phases across register settings
    set_regs(64, $urandom_range(65535), 655, 1024);
    add_random(400);
    drain();
    set_regs(5, 65535, 65535, 3);
    add_random(400);
    drain();
    idle_pct = 65;
    set_regs(0, 0, 0, 0);
    add_random(400);
    drain();
    idle_pct = 0;
    set_regs(127, $urandom_range(65535), $urandom_range(65535), 2047);
    add_random(400);
    drain();

    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
